[sv/fcsgc_pkg.sv]
// Package: shared types, status codes and the byte-wise CRC shift function.
package fcsgc_pkg;

    localparam int unsigned CRC_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

    typedef enum logic [2:0] {
        ST_GENERATED  = 3'd0,
        ST_RAW_MATCH  = 3'd1,
        ST_CPL_MATCH  = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_TOO_SHORT  = 3'd4
    } status_t;

    // Frame summary handed from the byte engine to the finishing stages.
    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] trailing;
        logic             gen_mode;
        logic             too_short;
    } frame_snap_t;

    // Byte placed above the register, 8 right shifts, reflected polynomial.
    function automatic logic [CRC_W-1:0] shift_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W+BYTE_W-1:0] r;
        r = {b, crc};
        for (int k = 0; k < BYTE_W; k++) begin
            if (r[0])
            begin
                r = (r >> 1) ^ {{BYTE_W{1'b0}}, poly};
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r[CRC_W-1:0];
    endfunction

endpackage

[sv/fcsgc_frame.sv]
// Input register and per-byte frame engine: CRC update, trailing pair, byte count.
module fcsgc_frame (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic                         operation,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    input  logic [15:0]                  poly,
    output logic                         snap_valid,
    output fcsgc_pkg::frame_snap_t       snap
);
    import fcsgc_pkg::*;

    logic              s0_valid_reg;
    logic              s0_op_reg;
    logic [BYTE_W-1:0] s0_byte_reg;
    logic              s0_last_reg;

    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [CRC_W-1:0]   pair_reg, pair_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               mode_reg, mode_next;
    logic               full_reg, full_next;

    logic               snap_valid_reg, snap_valid_next;
    frame_snap_t        snap_reg, snap_next;

    logic               mode_eff;
    logic               upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s0_op_reg   <= operation;
            s0_byte_reg <= data_byte;
            s0_last_reg <= last_byte;
        end
    end

    assign upd      = adv && s0_valid_reg;
    assign mode_eff = (count_reg == '0) ? s0_op_reg : mode_reg;

    always_comb
    begin
        crc_next   = crc_reg;
        first_next = first_reg;
        pair_next  = pair_reg;
        count_next = count_reg;
        mode_next  = mode_eff;
        full_next  = full_reg;

        if (count_reg == '0)
        begin
            first_next = s0_byte_reg;
        end
        else if (count_reg == COUNT_W'(1))
        begin
            crc_next = ~{s0_byte_reg, first_reg};
        end
        else if (mode_reg)
        begin
            crc_next = shift_byte(crc_reg, s0_byte_reg, poly);
        end
        else
        begin
            if (full_reg)
            begin
                crc_next = shift_byte(crc_reg, pair_reg[BYTE_W-1:0], poly);
            end
            else if (count_reg == COUNT_MAX)
            begin
                full_next = 1'b1;
            end
            pair_next = {s0_byte_reg, pair_reg[CRC_W-1:BYTE_W]};
        end
        if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end

        snap_next.crc       = crc_next;
        snap_next.trailing  = pair_next;
        snap_next.gen_mode  = mode_eff;
        snap_next.too_short = mode_eff ? (count_reg == '0) : (count_reg != COUNT_MAX);
        snap_valid_next     = s0_valid_reg && s0_last_reg;

        // End of frame: everything but the polynomial returns to zero.
        if (s0_last_reg)
        begin
            crc_next   = '0;
            first_next = '0;
            pair_next  = '0;
            count_next = '0;
            mode_next  = 1'b0;
            full_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            first_reg      <= '0;
            pair_reg       <= '0;
            count_reg      <= '0;
            mode_reg       <= 1'b0;
            full_reg       <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            snap_valid_reg <= snap_valid_next;
            if (upd)
            begin
                crc_reg   <= crc_next;
                first_reg <= first_next;
                pair_reg  <= pair_next;
                count_reg <= count_next;
                mode_reg  <= mode_next;
                full_reg  <= full_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

[sv/fcsgc_finish.sv]
// Finishing stages: two zero-byte shifts, FCS compare and the result register.
module fcsgc_finish (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   snap_valid,
    input  fcsgc_pkg::frame_snap_t snap,
    input  logic [15:0]            poly,
    output logic                   out_valid,
    output logic [15:0]            fcs_value,
    output logic [2:0]             status
);
    import fcsgc_pkg::*;

    logic             mid_valid_reg;
    frame_snap_t      mid_reg, mid_next;
    logic             res_valid_reg;
    logic [CRC_W-1:0] fcs_reg, fcs_next;
    status_t          status_reg, status_next;
    logic [CRC_W-1:0] r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= snap_valid;
            res_valid_reg <= mid_valid_reg;
        end
    end

    always_comb
    begin
        mid_next     = snap;
        mid_next.crc = shift_byte(snap.crc, '0, poly);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mid_reg    <= mid_next;
            fcs_reg    <= fcs_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        r = shift_byte(mid_reg.crc, '0, poly);
        if (mid_reg.too_short)
        begin
            fcs_next    = '0;
            status_next = ST_TOO_SHORT;
        end
        else if (mid_reg.gen_mode)
        begin
            fcs_next    = ~r;
            status_next = ST_GENERATED;
        end
        else
        begin
            fcs_next = r;
            if (r == mid_reg.trailing)
            begin
                status_next = ST_RAW_MATCH;
            end
            else if (~r == mid_reg.trailing)
            begin
                status_next = ST_CPL_MATCH;
            end
            else
            begin
                status_next = ST_MISMATCH;
            end
        end
    end

    assign out_valid = res_valid_reg;
    assign fcs_value = fcs_reg;
    assign status    = status_reg;

endmodule

[sv/frame_fcs_generate_check_top.sv]
// Top level: frame FCS generator and checker, reflected 16-bit CRC, one byte per beat.
// Takes one frame byte per clock cycle while in_stall is low, back to back, with no
// gaps needed between frames. The operation bit of a frame's first beat selects
// generate (1) or check (0). One result beat follows each beat marked last_byte, after
// that beat passes the four-stage pipe (input register, byte CRC engine, first and second
// zero-byte stages into the result register). A stall on the output holds the whole
// pipe, so in_stall follows out_stall while a result is waiting. The polynomial
// register resets to 0x8408 and is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while no frame is in flight, which the block itself does not enforce.
module frame_fcs_generate_check_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] fcs_value,
    output logic [2:0]  status
);
    import fcsgc_pkg::*;

    localparam logic [CRC_W-1:0] POLY_RESET = 16'h8408;

    logic [CRC_W-1:0] poly_reg;
    logic             adv;
    logic             snap_valid;
    frame_snap_t      snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
        end
        else if (cfg_wr_en)
        begin
            poly_reg <= cfg_wr_data;
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    fcsgc_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .operation  (operation),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .poly       (poly_reg),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    fcsgc_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .snap_valid (snap_valid),
        .snap       (snap),
        .poly       (poly_reg),
        .out_valid  (out_valid),
        .fcs_value  (fcs_value),
        .status     (status)
    );

    a_short_zero_fcs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_TOO_SHORT) |-> (fcs_value == '0))
        else $error("too-short frame with nonzero fcs");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input beat taken while result stalled");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared without pipe advance");

endmodule

[dv/frame_fcs_generate_check_top_test.sv]
// Self-checking testbench for frame_fcs_generate_check_top against a byte-level FCS predictor.
module frame_fcs_generate_check_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcsgc_pkg::*;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        last;
    } line_beat_t;

    typedef struct packed {
        logic [CRC_W-1:0] fcs;
        status_t          st;
    } fcs_result_t;

    typedef enum logic [1:0] {
        FCS_RAW,
        FCS_CPL,
        FCS_BAD
    } trailer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] fcs_value;
    logic [2:0]  status;

    frame_fcs_generate_check_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fcs_value   (fcs_value),
        .status      (status)
    );

    // predictor state
    logic [CRC_W-1:0]   poly_now = 16'h8408;
    logic [CRC_W-1:0]   crc_acc = '0;
    logic [BYTE_W-1:0]  head_byte = '0;
    logic [CRC_W-1:0]   tail_pair = '0;
    logic [COUNT_W-1:0] seen_cnt = '0;
    logic               gen_frame = 1'b0;
    logic               tail_full = 1'b0;

    fcs_result_t fcs_expected[$];
    line_beat_t  beat_queue[$];
    logic [7:0]  frame_buf[$];
    logic [15:0] line_poly = 16'h8408;

    int errors = 0;
    int beats_queued = 0;
    int beats_in = 0;
    int frames_checked = 0;
    int poly_settings = 1;
    int status_tally[5] = '{0, 0, 0, 0, 0};

    bit sender_steady = 1'b0;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;
    int src_wait = 0;
    int sink_wait = 0;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int holds_done = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CRC_W-1:0] crc_shift8(
        input logic [CRC_W-1:0]  c_in,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  p
    );
        logic [CRC_W-1:0] c;
        logic             fb;
        c = c_in;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb = c[0];
            c = {b[k], c[CRC_W-1:1]} ^ (fb ? p : '0);
        end
        return c;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic absorb_byte(input logic op, input logic [7:0] b, input logic lst);
        logic [COUNT_W-1:0] c;
        logic [CRC_W-1:0]   r;
        fcs_result_t        res;
        c = seen_cnt;
        if (c == 0)
        begin
            gen_frame = op;
            head_byte = b;
        end
        else if (c == 1)
            crc_acc = ~{b, head_byte};
        else if (gen_frame)
            crc_acc = crc_shift8(crc_acc, b, poly_now);
        else
        begin
            if (tail_full)
                crc_acc = crc_shift8(crc_acc, tail_pair[7:0], poly_now);
            else if (c == COUNT_MAX)
                tail_full = 1'b1;
            tail_pair = {b, tail_pair[15:8]};
        end
        if (c != COUNT_MAX)
            seen_cnt = c + 1'b1;
        if (lst)
        begin
            r = crc_shift8(crc_shift8(crc_acc, 8'h00, poly_now), 8'h00, poly_now);
            res.fcs = '0;
            if (gen_frame)
            begin
                if (c == 0)
                    res.st = ST_TOO_SHORT;
                else
                begin
                    res.fcs = ~r;
                    res.st = ST_GENERATED;
                end
            end
            else if (c != COUNT_MAX)
                res.st = ST_TOO_SHORT;
            else
            begin
                res.fcs = r;
                if (r == tail_pair)
                    res.st = ST_RAW_MATCH;
                else if (~r == tail_pair)
                    res.st = ST_CPL_MATCH;
                else
                    res.st = ST_MISMATCH;
            end
            fcs_expected.push_back(res);
            crc_acc = '0;
            head_byte = '0;
            tail_pair = '0;
            seen_cnt = '0;
            gen_frame = 1'b0;
            tail_full = 1'b0;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        line_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_byte(operation, data_byte, last_byte);
                beats_in++;
                if ($urandom_range(0, 99) == 0)
                    src_calm = !src_calm;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    in_valid <= 1'b0;
                end
                else if (beat_queue.size() > 0)
                begin
                    nxt = beat_queue.pop_front();
                    operation <= nxt.op;
                    data_byte <= nxt.data;
                    last_byte <= nxt.last;
                    in_valid <= 1'b1;
                    src_wait = pick_gap(src_calm || sender_steady);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        fcs_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (fcs_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat fcs %h status %0d",
                        $time, fcs_value, status);
                end
                else
                begin
                    want = fcs_expected.pop_front();
                    frames_checked++;
                    if (fcs_value !== want.fcs)
                    begin
                        errors++;
                        $display("%0t: fcs_value expected %h actual %h",
                            $time, want.fcs, fcs_value);
                    end
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                            $time, want.st, status);
                    end
                    status_tally[int'(want.st)]++;
                end
            end
            if ($urandom_range(0, 149) == 0)
                sink_calm = !sink_calm;
            if (hold_seen != hold_ticket)
            begin
                hold_seen = hold_ticket;
                hold_left = 400;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                sink_wait = pick_gap(sink_calm);
            end
        end
    end

    task automatic fill_frame(input int n, input int v);
        int r;
        frame_buf.delete();
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (v >= 0)
                frame_buf.push_back(v[7:0]);
            else if (r == 0)
                frame_buf.push_back(8'h00);
            else if (r == 1)
                frame_buf.push_back(8'hFF);
            else
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = ~{frame_buf[1], frame_buf[0]};
        for (int i = 2; i < frame_buf.size(); i++)
            c = crc_shift8(c, frame_buf[i], line_poly);
        return crc_shift8(crc_shift8(c, 8'h00, line_poly), 8'h00, line_poly);
    endfunction

    task automatic append_fcs(input trailer_t kind);
        logic [15:0] f;
        f = frame_crc();
        if (kind == FCS_CPL)
            f = ~f;
        else if (kind == FCS_BAD)
            f = f ^ 16'($urandom_range(1, 16'hFFFE));
        frame_buf.push_back(f[7:0]);
        frame_buf.push_back(f[15:8]);
    endtask

    task automatic send_frame(input logic op);
        line_beat_t bt;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            bt.op = (i == 0) ? op : 1'($urandom_range(0, 1));
            bt.data = frame_buf[i];
            bt.last = (i == frame_buf.size() - 1);
            beat_queue.push_back(bt);
            beats_queued++;
        end
    endtask

    task automatic random_frame();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 12);
        if (r < 88)
        begin
            fill_frame(n, -1);
            if (r < 38)
            begin
                append_fcs(FCS_RAW);
                send_frame(1'b0);
            end
            else if (r < 53)
            begin
                append_fcs(FCS_CPL);
                send_frame(1'b0);
            end
            else if (r < 63)
            begin
                append_fcs(FCS_BAD);
                send_frame(1'b0);
            end
            else
                send_frame(1'b1);
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            fill_frame(1, -1);
            send_frame(1'b1);
        end
        else
        begin
            fill_frame($urandom_range(1, 3), -1);
            send_frame(1'b0);
        end
    endtask

    task automatic drain();
        while (beat_queue.size() != 0 || in_valid || fcs_expected.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_poly(input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        poly_now = v;
        line_poly = v;
        poly_settings++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] poly_plan[8];
        int          target;
        poly_plan = '{16'hFFFF, 16'h0000, 16'h8408, 16'h0001,
                      16'h8000, 16'h1021, 16'h0000, 16'h8408};
        poly_plan[5] = 16'($urandom_range(0, 16'hFFFF));
        poly_plan[6] = 16'($urandom_range(0, 16'hFFFF));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short frames, extremes, each check outcome
        fill_frame(1, 8'hFF);
        send_frame(1'b1);
        fill_frame(2, 8'h00);
        send_frame(1'b1);
        fill_frame(3, 8'hFF);
        send_frame(1'b1);
        fill_frame(1, 8'h00);
        send_frame(1'b0);
        fill_frame(2, 8'hFF);
        send_frame(1'b0);
        fill_frame(3, 8'h00);
        frame_buf[1] = 8'hFF;
        send_frame(1'b0);
        fill_frame(2, 8'hFF);
        append_fcs(FCS_RAW);
        send_frame(1'b0);
        fill_frame(2, 8'h00);
        append_fcs(FCS_CPL);
        send_frame(1'b0);
        fill_frame(3, 8'hA5);
        append_fcs(FCS_BAD);
        send_frame(1'b0);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_poly(poly_plan[ph]);
            if (ph == 2)
            begin
                sender_steady = 1'b1;
                hold_ticket++;
            end
            target = beats_queued + 190;
            while (beats_queued < target)
                random_frame();
            if (ph == 2)
            begin
                drain();
                sender_steady = 1'b0;
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("summary: %0d beats in %0d checked frames over %0d polynomial settings",
            beats_in, frames_checked, poly_settings);
        $display("summary: gen %0d, raw %0d, cpl %0d, mismatch %0d, short %0d, long holds %0d",
            status_tally[0], status_tally[1], status_tally[2], status_tally[3],
            status_tally[4], holds_done);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/fcsgc_pkg.sv
sv/fcsgc_frame.sv
sv/fcsgc_finish.sv
sv/frame_fcs_generate_check_top.sv
dv/frame_fcs_generate_check_top_test.sv
